// File: rtl/qsm_pkg.sv
package qsm_pkg;

  localparam int CNT_W   = 9;   // signed edge count
  localparam int CPC_W   = 8;   // counts_per_cm register
  localparam int TMO_W   = 16;  // timeout_ms register
  localparam int TIME_W  = 32;  // timestamps
  localparam int SPEED_W = 15;  // signed speed word
  localparam int QUO_W   = 14;  // quotient magnitude, holds 10000
  localparam int STEP_W  = 4;   // divider step counter
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [QUO_W-1:0] SPEED_NUMERATOR = 14'd10000;
  localparam logic [CPC_W-1:0] CPC_RESET       = 8'd12;
  localparam logic [TMO_W-1:0] TMO_RESET       = 16'd700;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNTS_PER_CM = 2'd0,
    CFG_TIMEOUT_MS    = 2'd1
  } cfg_idx_t;

endpackage

// File: rtl/quadrature_speed_meter_unit.sv
// Quadrature speed meter: one input word per edge on encoder line A.
// Edges that do not complete a centimeter only move the count; they give no word and no stall.
// A completing edge stalls input through the evaluate and result states on timeout or zero
// elapsed time, else also through 14 restoring-divider steps on one shared subtract/compare.
// Result word is registered at the edge that ends the stall; a word still held downstream
// delays that edge. Reset (synchronous, rst_n low): count and last
// timestamp cleared, registers to defaults.
module quadrature_speed_meter_unit
  import qsm_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  // input channel: one word per A edge
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_a_level,
  input  logic                         in_b_level,
  input  logic [TIME_W-1:0]            in_now_ms,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [SPEED_W-1:0]    out_speed_mm_s,
  output logic                         out_timed_out
);

  typedef enum logic [1:0] {
    ST_IDLE,  // take edges, update count
    ST_EVAL,  // timeout / zero-elapsed check, divider load
    ST_DIV,   // one quotient bit per cycle
    ST_DONE   // wait for output register
  } state_t;

  state_t                     state_r;
  logic [CPC_W-1:0]           cpc_r;
  logic [TMO_W-1:0]           tmo_r;
  logic [CNT_W-1:0]           count_r;
  logic [TIME_W-1:0]          last_r;
  logic [TIME_W-1:0]          elapsed_r;
  logic                       neg_r;
  logic                       to_r;
  logic [QUO_W-1:0]           quo_r;    // dividend shifts out, quotient shifts in
  logic [TMO_W-1:0]           rem_r;
  logic [STEP_W-1:0]          step_r;
  logic                       out_valid_r;
  logic signed [SPEED_W-1:0]  out_speed_r;
  logic                       out_to_r;

  logic                       in_acc;
  logic                       out_free;
  logic                       out_load;
  logic [CNT_W-1:0]           cnt_step;
  logic [CNT_W-1:0]           pos_thr;
  logic [CNT_W-1:0]           neg_thr;
  logic                       hit;
  logic                       over_tmo;
  logic [TMO_W:0]             trial;
  logic                       trial_ge;
  logic [TMO_W-1:0]           trial_sub;
  logic [SPEED_W-1:0]         mag_ext;

  assign in_stall       = (state_r != ST_IDLE);
  assign in_acc         = in_valid && !in_stall;
  assign out_valid      = out_valid_r;
  assign out_speed_mm_s = out_speed_r;
  assign out_timed_out  = out_to_r;
  assign out_free       = !out_valid_r || !out_stall;
  assign out_load       = (state_r == ST_DONE) && out_free;

  // count moves down when A equals B, up otherwise; 9-bit wrap
  assign cnt_step = (in_a_level == in_b_level) ? (count_r - 1'b1) : (count_r + 1'b1);
  assign pos_thr  = {1'b0, cpc_r};
  assign neg_thr  = {CNT_W{1'b0}} - pos_thr;
  assign hit      = (cnt_step == pos_thr) || (cnt_step == neg_thr);

  assign over_tmo = (elapsed_r[TIME_W-1:TMO_W] != '0) || (elapsed_r[TMO_W-1:0] > tmo_r);

  // shared divider step: divisor is elapsed_r[15:0]
  assign trial     = {rem_r, quo_r[QUO_W-1]};
  assign trial_ge  = trial >= {1'b0, elapsed_r[TMO_W-1:0]};
  assign trial_sub = TMO_W'(trial - {1'b0, elapsed_r[TMO_W-1:0]});

  assign mag_ext = {1'b0, quo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cpc_r       <= CPC_RESET;
      tmo_r       <= TMO_RESET;
      count_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COUNTS_PER_CM: cpc_r <= cfg_data[CPC_W-1:0];
          CFG_TIMEOUT_MS:    tmo_r <= cfg_data[TMO_W-1:0];
          default: ;
        endcase
      end

      // load wins over drain; a held word is never replaced
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (hit) begin
              count_r   <= '0;
              neg_r     <= cnt_step[CNT_W-1];
              elapsed_r <= in_now_ms - last_r;
              last_r    <= in_now_ms;
              state_r   <= ST_EVAL;
            end else begin
              count_r <= cnt_step;
            end
          end
        end
        ST_EVAL: begin
          if (over_tmo) begin
            quo_r   <= '0;
            to_r    <= 1'b1;
            state_r <= ST_DONE;
          end else if (elapsed_r[TMO_W-1:0] == '0) begin
            quo_r   <= SPEED_NUMERATOR;   // saturate on zero elapsed
            to_r    <= 1'b0;
            state_r <= ST_DONE;
          end else begin
            quo_r   <= SPEED_NUMERATOR;
            rem_r   <= '0;
            to_r    <= 1'b0;
            step_r  <= STEP_W'(QUO_W - 1);
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= trial_ge ? trial_sub : trial[TMO_W-1:0];
          quo_r <= {quo_r[QUO_W-2:0], trial_ge};
          if (step_r == '0) begin
            state_r <= ST_DONE;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_speed_r <= neg_r ? -$signed(mag_ext) : $signed(mag_ext);
            out_to_r    <= to_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // timed-out word always carries zero speed
  a_tmo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_to_r |-> out_speed_r == '0)
    else $error("timed-out word with nonzero speed");

  // speed stays within +/-10000
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_speed_r <= 15'sd10000) && (out_speed_r >= -15'sd10000))
    else $error("speed out of range");

  // a completion always clears the count
  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EVAL |-> count_r == '0)
    else $error("count not cleared on completion");

  // divider runs only into itself or the result stage
  a_div_flow: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |=> state_r == ST_DIV || state_r == ST_DONE)
    else $error("divider left early");

  // a result never overwrites a word still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_speed_r) && $stable(out_to_r))
    else $error("held result word changed");

endmodule

// File: sim/tb_top.sv
module tb_top
  import qsm_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Speed word for a full centimeter in one millisecond (or less).
  localparam logic [TIME_W-1:0] FULL_SCALE = 32'd10000;
  // Margin for the slowest completing edge, through the divider, before a config write.
  localparam int unsigned DRAIN_CYCLES = 24;
  // Register indexes with no register behind them; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum int unsigned {
    PACE_FREE,
    PACE_SENDER,
    PACE_RECEIVER,
    PACE_BOTH
  } pace_t;

  // One encoder edge as it goes into the block.
  typedef struct packed {
    logic              a;
    logic              b;
    logic [TIME_W-1:0] now;
  } edge_word_t;

  // One speed report as it should come out.
  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic                      timed_out;
  } speed_word_t;

  // DUT ports; every input is known from time zero.
  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_a_level = 1'b0;
  logic                      in_b_level = 1'b0;
  logic [TIME_W-1:0]         in_now_ms = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [SPEED_W-1:0] out_speed_mm_s;
  logic                      out_timed_out;

  // Edges waiting for the driver, and speed words waiting for the monitor.
  edge_word_t  edge_pending_q[$];
  speed_word_t speed_expect_q[$];

  // Shadow of the wheel: edge count, last completion stamp and both registers.
  logic [CNT_W-1:0]  wheel_count = '0;
  logic [TIME_W-1:0] wheel_last_ms = '0;
  logic [CPC_W-1:0]  shadow_cpc = CPC_RESET;
  logic [TMO_W-1:0]  shadow_tmo = TMO_RESET;

  // Pacing knobs, changed only between phases (at a falling edge).
  int unsigned sender_gap_pct = 0;
  int unsigned receiver_hold_pct = 0;
  int unsigned mismatch_count = 0;

  // Stimulus generator state: running timestamp and travel direction.
  logic [TIME_W-1:0] gen_now = '0;
  bit                gen_up = 1'b1;

  edge_word_t  next_word;
  speed_word_t head_word;

  quadrature_speed_meter_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_a_level     (in_a_level),
    .in_b_level     (in_b_level),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_speed_mm_s (out_speed_mm_s),
    .out_timed_out  (out_timed_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses a word.
  initial begin
    #4_000_000;
    $display("quadrature_speed_meter_unit regression: fail");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Advance the shadow wheel by one accepted edge; queue a speed word when a
  // centimeter completes. Count is 9-bit two's complement and matches by equality
  // only, so a count left beyond a lowered threshold wraps around before it hits.
  function automatic void account_edge(input logic a, input logic b,
                                       input logic [TIME_W-1:0] now);
    logic [CNT_W-1:0]   pos_thr;
    logic [CNT_W-1:0]   neg_thr;
    logic [TIME_W-1:0]  elapsed;
    logic [TIME_W-1:0]  quot;
    logic [SPEED_W-1:0] mag;
    logic               reverse;
    speed_word_t        res;
    pos_thr = {1'b0, shadow_cpc};
    neg_thr = -pos_thr;
    if (a == b) begin
      wheel_count = wheel_count - 1'b1;
    end else begin
      wheel_count = wheel_count + 1'b1;
    end
    if (wheel_count != pos_thr && wheel_count != neg_thr) return;
    reverse = wheel_count[CNT_W-1];
    elapsed = now - wheel_last_ms;   // wraps at 32 bits
    wheel_last_ms = now;
    wheel_count = '0;
    if (elapsed > shadow_tmo) begin
      res.speed = '0;
      res.timed_out = 1'b1;
    end else begin
      // zero elapsed time saturates at full scale
      quot = (elapsed == '0) ? FULL_SCALE : FULL_SCALE / elapsed;
      mag = quot[SPEED_W-1:0];
      res.speed = reverse ? -mag : mag;
      res.timed_out = 1'b0;
    end
    speed_expect_q.push_back(res);
  endfunction

  // Driver: holds the word while stalled, predicts on acceptance, then either
  // presents the next pending edge or drops valid.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      wheel_count = '0;
      wheel_last_ms = '0;
      shadow_cpc = CPC_RESET;
      shadow_tmo = TMO_RESET;
    end else begin
      if (in_valid && !in_stall) begin
        account_edge(in_a_level, in_b_level, in_now_ms);
      end
      if (!in_valid || !in_stall) begin
        if (edge_pending_q.size() != 0 && $urandom_range(99, 0) >= sender_gap_pct) begin
          next_word = edge_pending_q.pop_front();
          in_valid <= 1'b1;
          in_a_level <= next_word.a;
          in_b_level <= next_word.b;
          in_now_ms <= next_word.now;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted speed word against the oldest prediction and
  // throws random back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (speed_expect_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected word speed %0d timed_out %0b",
                                  out_speed_mm_s, out_timed_out));
        end else begin
          head_word = speed_expect_q.pop_front();
          if (out_speed_mm_s !== head_word.speed) begin
            flag_mismatch($sformatf("speed_mm_s %0d, expected %0d",
                                    out_speed_mm_s, head_word.speed));
          end
          if (out_timed_out !== head_word.timed_out) begin
            flag_mismatch($sformatf("timed_out %0b, expected %0b",
                                    out_timed_out, head_word.timed_out));
          end
        end
      end
      out_stall <= $urandom_range(99, 0) < receiver_hold_pct;
    end
  end

  // Register write, one cycle of enable; shadow follows at the edge the block takes it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_COUNTS_PER_CM) begin
      shadow_cpc = val[CPC_W-1:0];
    end else if (idx == CFG_TIMEOUT_MS) begin
      shadow_tmo = val[TMO_W-1:0];
    end
    @(negedge clk);
  endtask

  // Wait until every edge is in and every speed word is out, then wait out the
  // drain margin before going on.
  task automatic settle();
    while (edge_pending_q.size() != 0 || in_valid || speed_expect_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic queue_edge(input bit up, input logic [TIME_W-1:0] stamp);
    edge_word_t w;
    w.a = $urandom_range(1, 0);
    w.b = up ? ~w.a : w.a;
    w.now = stamp;
    edge_pending_q.push_back(w);
  endtask

  // Mostly steady travel in one direction with small timestamp steps; a few
  // direction flips, repeated stamps, long gaps and wild jumps mixed in.
  task automatic queue_travel(input int unsigned n, input int unsigned max_step,
                              input int unsigned flip_pct);
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99, 0);
      if ($urandom_range(99, 0) < flip_pct) gen_up = ~gen_up;
      if (pick < 3) begin
        gen_now = $urandom();
      end else if (pick < 6) begin
        gen_now = gen_now + $urandom_range(20000, 700);
      end else if (pick >= 20) begin
        gen_now = gen_now + $urandom_range(max_step, 1);
      end
      queue_edge(gen_up, gen_now);
    end
  endtask

  task automatic run_phase(input logic [CPC_W-1:0] cpc, input logic [TMO_W-1:0] tmo,
                           input pace_t pace, input int unsigned n,
                           input int unsigned max_step, input int unsigned flip_pct);
    settle();
    // upper data bits are don't-care for the 8-bit register
    write_reg(CFG_COUNTS_PER_CM, {8'($urandom_range(255, 0)), cpc});
    write_reg(CFG_TIMEOUT_MS, tmo);
    sender_gap_pct = (pace == PACE_SENDER) ? 54 : (pace == PACE_BOTH) ? 27 : 0;
    receiver_hold_pct = (pace == PACE_RECEIVER) ? 54 : (pace == PACE_BOTH) ? 27 : 0;
    queue_travel(n, max_step, flip_pct);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset defaults: 12 counts per cm, 700 ms timeout. One cm in 120 ms.
    for (int k = 1; k <= 12; k++) begin
      queue_edge(1'b1, 32'(10 * k));
    end
    settle();

    // One count per cm: every edge reports.
    write_reg(CFG_COUNTS_PER_CM, 16'd1);
    queue_edge(1'b1, 32'd120);          // zero elapsed, forward saturates
    queue_edge(1'b0, 32'd120);          // zero elapsed, reverse saturates
    queue_edge(1'b0, 32'd121);          // 1 ms, reverse full scale
    queue_edge(1'b1, 32'd123);
    queue_edge(1'b0, 32'd130);          // truncating divide, negative
    queue_edge(1'b1, 32'd830);          // exactly at timeout: still a speed
    queue_edge(1'b1, 32'd1531);         // one past timeout
    queue_edge(1'b0, 32'hFFFF_FFFF);    // huge gap, times out
    queue_edge(1'b1, 32'd5);            // stamp wraps: 6 ms elapsed
    queue_edge(1'b1, 32'd704);
    queue_edge(1'b0, 32'd707);
    gen_now = 32'd707;

    // Random travel over a range of settings and pacing.
    run_phase(8'd2, 16'd700, PACE_FREE, 150, 150, 3);
    run_phase(8'd1, 16'd0, PACE_SENDER, 100, 3, 5);            // any gap times out
    run_phase(8'd5, 16'hFFFF, PACE_RECEIVER, 150, 4000, 3);    // slow: speeds near 0
    run_phase(8'd0, 16'd300, PACE_BOTH, 120, 100, 50);         // completes on return to 0
    run_phase(8'd255, 16'hFFFF, PACE_FREE, 280, 10, 0);
    // Threshold moved to 30 with a count left over from the last phase.
    run_phase(8'd30, 16'd1000, PACE_SENDER, 450, 8, 0);

    settle();
    write_reg(CFG_SPARE_LO, 16'($urandom()));
    write_reg(CFG_SPARE_HI, 16'($urandom()));
    run_phase(8'd12, 16'd700, PACE_BOTH, 200, 90, 3);
    run_phase(8'($urandom_range(20, 1)), 16'($urandom()), PACE_RECEIVER, 180, 200, 3);

    settle();
    if (mismatch_count == 0) begin
      $display("quadrature_speed_meter_unit regression: pass");
    end else begin
      $display("quadrature_speed_meter_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/qsm_pkg.sv
rtl/quadrature_speed_meter_unit.sv
sim/tb_top.sv
